// ===== design/lfr_pkg.sv =====
// Shared types and constants for the LCD frame trigger register block.
package lfr_pkg;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam int OFS_W = 10;

    localparam logic [OFS_W-1:0] OFS_CTRL      = 10'h000;
    localparam logic [OFS_W-1:0] OFS_CTRL_SET  = 10'h004;
    localparam logic [OFS_W-1:0] OFS_CTRL_CLR  = 10'h008;
    localparam logic [OFS_W-1:0] OFS_CTRL1     = 10'h010;
    localparam logic [OFS_W-1:0] OFS_CTRL1_SET = 10'h014;
    localparam logic [OFS_W-1:0] OFS_CTRL1_CLR = 10'h018;
    localparam logic [OFS_W-1:0] OFS_XFER      = 10'h030;
    localparam logic [OFS_W-1:0] OFS_BUF       = 10'h040;
    localparam logic [OFS_W-1:0] OFS_TIMING    = 10'h060;

    localparam logic [31:0] RUN_BIT    = 32'h0000_0001;
    localparam logic [31:0] FRAME_DONE = 32'h0000_0200;

    localparam logic [31:0] FRAME_BYTES_DEFAULT = 32'd15360;

    typedef struct packed {
        logic             mode;
        logic [OFS_W-1:0] offset;
        logic [31:0]      write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        frame_started;
        logic        fetch_request;
        logic [31:0] fetch_address;
    } rsp_t;

endpackage

// ===== design/lcd_frame_trigger_registers_core.sv =====
// Register block of a simple LCD controller: control set/clear aliases and frame trigger.
//
// Each request transaction is one register read or write; every request yields
// exactly one response transaction. The register update and the response are
// computed in the cycle the request is accepted and the response is held in an
// output register, so one request is taken per clock whenever the response side
// is not stalled. The critical path is the 16x16
// width-by-height product compared against FRAME_BYTES on a frame start.
module lcd_frame_trigger_registers_core #(
    parameter logic [31:0] FRAME_BYTES = lfr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lfr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lfr_pkg::rsp_t rsp
);

    logic [31:0] ctrl_reg,      ctrl_next;
    logic [31:0] ctrl_set_reg,  ctrl_set_next;
    logic [31:0] ctrl_clr_reg,  ctrl_clr_next;
    logic [31:0] ctrl1_reg,     ctrl1_next;
    logic [31:0] ctrl1_set_reg, ctrl1_set_next;
    logic [31:0] ctrl1_clr_reg, ctrl1_clr_next;
    logic [15:0] height_reg,    height_next;
    logic [15:0] width_reg,     width_next;
    logic [31:0] buf_reg,       buf_next;
    logic [31:0] timing_reg,    timing_next;
    logic        irq_reg,       irq_next;
    logic        rsp_valid_reg;
    lfr_pkg::rsp_t rsp_reg,     rsp_next;

    logic        accept;
    logic [31:0] area;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign area      = {16'd0, width_reg} * {16'd0, height_reg};

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        ctrl_set_next  = ctrl_set_reg;
        ctrl_clr_next  = ctrl_clr_reg;
        ctrl1_next     = ctrl1_reg;
        ctrl1_set_next = ctrl1_set_reg;
        ctrl1_clr_next = ctrl1_clr_reg;
        height_next    = height_reg;
        width_next     = width_reg;
        buf_next       = buf_reg;
        timing_next    = timing_reg;
        irq_next       = irq_reg;
        rsp_next       = '0;

        if (req.mode == lfr_pkg::MODE_READ)
        begin
            case (req.offset)
                lfr_pkg::OFS_CTRL:      rsp_next.read_data = ctrl_reg;
                lfr_pkg::OFS_CTRL_SET:  rsp_next.read_data = ctrl_set_reg;
                lfr_pkg::OFS_CTRL_CLR:  rsp_next.read_data = ctrl_clr_reg;
                lfr_pkg::OFS_CTRL1:     rsp_next.read_data = ctrl1_reg;
                lfr_pkg::OFS_CTRL1_SET: rsp_next.read_data = ctrl1_set_reg;
                lfr_pkg::OFS_CTRL1_CLR: rsp_next.read_data = ctrl1_clr_reg;
                lfr_pkg::OFS_TIMING:    rsp_next.read_data = timing_reg;
                default:                rsp_next.read_data = '0;
            endcase
        end
        else
        begin
            case (req.offset)
                lfr_pkg::OFS_CTRL:
                    ctrl_next = req.write_data;
                lfr_pkg::OFS_CTRL_SET:
                begin
                    ctrl_set_next = req.write_data;
                    ctrl_next     = ctrl_reg | req.write_data;
                    // frame start: run bit self-clears in the same access
                    if (req.write_data == lfr_pkg::RUN_BIT)
                    begin
                        ctrl_next              = ctrl_next & ~lfr_pkg::RUN_BIT;
                        ctrl1_next             = ctrl1_reg | lfr_pkg::FRAME_DONE;
                        irq_next               = 1'b1;
                        rsp_next.frame_started = 1'b1;
                        if (area == FRAME_BYTES)
                        begin
                            rsp_next.fetch_request = 1'b1;
                            rsp_next.fetch_address = buf_reg;
                        end
                    end
                end
                lfr_pkg::OFS_CTRL_CLR:
                begin
                    ctrl_clr_next = req.write_data;
                    ctrl_next     = ctrl_reg & ~req.write_data;
                end
                lfr_pkg::OFS_CTRL1_SET:
                begin
                    ctrl1_set_next = req.write_data;
                    ctrl1_next     = ctrl1_reg | req.write_data;
                end
                lfr_pkg::OFS_CTRL1_CLR:
                begin
                    ctrl1_clr_next = req.write_data;
                    ctrl1_next     = ctrl1_reg & ~req.write_data;
                    if (req.write_data == lfr_pkg::FRAME_DONE)
                        irq_next = 1'b0;
                end
                lfr_pkg::OFS_XFER:
                begin
                    height_next = req.write_data[15:0];
                    width_next  = req.write_data[31:16];
                end
                lfr_pkg::OFS_BUF:
                    buf_next = req.write_data;
                lfr_pkg::OFS_TIMING:
                    timing_next = req.write_data;
                default:
                    ;
            endcase
        end
        rsp_next.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            ctrl_set_reg  <= '0;
            ctrl_clr_reg  <= '0;
            ctrl1_reg     <= '0;
            ctrl1_set_reg <= '0;
            ctrl1_clr_reg <= '0;
            height_reg    <= '0;
            width_reg     <= '0;
            buf_reg       <= '0;
            timing_reg    <= '0;
            irq_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ctrl_reg      <= ctrl_next;
                ctrl_set_reg  <= ctrl_set_next;
                ctrl_clr_reg  <= ctrl_clr_next;
                ctrl1_reg     <= ctrl1_next;
                ctrl1_set_reg <= ctrl1_set_next;
                ctrl1_clr_reg <= ctrl1_clr_next;
                height_reg    <= height_next;
                width_reg     <= width_next;
                buf_reg       <= buf_next;
                timing_reg    <= timing_next;
                irq_reg       <= irq_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== design/lfr_checker.sv =====
// Port-level assertions for the LCD frame trigger register block, with bind.
module lfr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input lfr_pkg::rsp_t rsp
);

    // every accepted request produces a response in the next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted request produced no response");

    // a stalled response must hold
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_fetch_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fetch_request |-> rsp.frame_started)
        else $error("fetch request without frame start");

    a_start_irq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.frame_started |-> rsp.irq_level && rsp.read_data == '0)
        else $error("frame start without interrupt or with read data");

    a_fetch_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.fetch_request |-> rsp.fetch_address == '0)
        else $error("fetch address nonzero without fetch request");

endmodule

bind lcd_frame_trigger_registers_core lfr_checker u_lfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== verif/lfr_response_check.sv =====
// Response checker for the LCD frame trigger register block: predicts each access and compares.
module lfr_response_check
    import lfr_pkg::*;
#(
    parameter logic [31:0] FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] ctrl_word;
    logic [31:0] ctrl_set_shadow;
    logic [31:0] ctrl_clr_shadow;
    logic [31:0] ctrl1_word;
    logic [31:0] ctrl1_set_shadow;
    logic [31:0] ctrl1_clr_shadow;
    logic [15:0] frame_h;
    logic [15:0] frame_w;
    logic [31:0] buffer_base;
    logic [31:0] timing_word;
    logic        irq_pending;

    rsp_t expected_rsp[$];
    rsp_t want;
    int   reported;

    // Applies one bus access to the register copy and returns the response it should produce.
    function automatic rsp_t apply_access(req_t a);
        rsp_t        r;
        logic [31:0] area;
        r = '0;
        if (a.mode == MODE_READ)
        begin
            case (a.offset)
                OFS_CTRL:      r.read_data = ctrl_word;
                OFS_CTRL_SET:  r.read_data = ctrl_set_shadow;
                OFS_CTRL_CLR:  r.read_data = ctrl_clr_shadow;
                OFS_CTRL1:     r.read_data = ctrl1_word;
                OFS_CTRL1_SET: r.read_data = ctrl1_set_shadow;
                OFS_CTRL1_CLR: r.read_data = ctrl1_clr_shadow;
                OFS_TIMING:    r.read_data = timing_word;
                default:       r.read_data = '0;
            endcase
        end
        else
        begin
            case (a.offset)
                OFS_CTRL: ctrl_word = a.write_data;
                OFS_CTRL_SET:
                begin
                    ctrl_set_shadow = a.write_data;
                    ctrl_word = ctrl_word | a.write_data;
                    if (a.write_data == RUN_BIT)
                    begin
                        area = {16'd0, frame_w} * {16'd0, frame_h};
                        if (area == FRAME_BYTES)
                        begin
                            r.fetch_request = 1'b1;
                            r.fetch_address = buffer_base;
                        end
                        r.frame_started = 1'b1;
                        // run bit is set and dropped in the same access
                        ctrl_word = ctrl_word & ~RUN_BIT;
                        ctrl1_word = ctrl1_word | FRAME_DONE;
                        irq_pending = 1'b1;
                    end
                end
                OFS_CTRL_CLR:
                begin
                    ctrl_clr_shadow = a.write_data;
                    ctrl_word = ctrl_word & ~a.write_data;
                end
                OFS_CTRL1_SET:
                begin
                    ctrl1_set_shadow = a.write_data;
                    ctrl1_word = ctrl1_word | a.write_data;
                end
                OFS_CTRL1_CLR:
                begin
                    ctrl1_clr_shadow = a.write_data;
                    ctrl1_word = ctrl1_word & ~a.write_data;
                    if (a.write_data == FRAME_DONE)
                        irq_pending = 1'b0;
                end
                OFS_XFER:
                begin
                    frame_h = a.write_data[15:0];
                    frame_w = a.write_data[31:16];
                end
                OFS_BUF:    buffer_base = a.write_data;
                OFS_TIMING: timing_word = a.write_data;
                default: ;
            endcase
        end
        r.irq_level = irq_pending;
        return r;
    endfunction

    task automatic log_failure(input string what, input rsp_t exp_rsp);
        fail_count++;
        if (reported < 10)
        begin
            reported++;
            $display("%0t: %s: read_data %h/%h irq %b/%b started %b/%b fetch %b/%b addr %h/%h",
                     $realtime, what, exp_rsp.read_data, rsp.read_data,
                     exp_rsp.irq_level, rsp.irq_level, exp_rsp.frame_started, rsp.frame_started,
                     exp_rsp.fetch_request, rsp.fetch_request,
                     exp_rsp.fetch_address, rsp.fetch_address);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_word = '0;
            ctrl_set_shadow = '0;
            ctrl_clr_shadow = '0;
            ctrl1_word = '0;
            ctrl1_set_shadow = '0;
            ctrl1_clr_shadow = '0;
            frame_h = '0;
            frame_w = '0;
            buffer_base = '0;
            timing_word = '0;
            irq_pending = 1'b0;
            expected_rsp.delete();
            fail_count = 0;
            reported = 0;
            outstanding = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(apply_access(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    log_failure("unexpected transaction (expected/actual)", '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp !== want)
                        log_failure("response mismatch (expected/actual)", want);
                end
            end
            outstanding = expected_rsp.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the LCD frame trigger register testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lfr_pkg::*;

    localparam logic [31:0] FRAME_SIZE = FRAME_BYTES_DEFAULT;
    localparam int PHASE_ITEMS = 475;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int fail_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent;

    always #5 clk = ~clk;

    lcd_frame_trigger_registers_core #(
        .FRAME_BYTES(FRAME_SIZE)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    lfr_response_check #(
        .FRAME_BYTES(FRAME_SIZE)
    ) u_response_check (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task automatic bus_access(input logic m, input logic [OFS_W-1:0] o, input logic [31:0] d);
        req_t item;
        item.mode = m;
        item.offset = o;
        item.write_data = d;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    function automatic logic [OFS_W-1:0] pick_register();
        case ($urandom_range(8))
            0:       return OFS_CTRL;
            1:       return OFS_CTRL_SET;
            2:       return OFS_CTRL_CLR;
            3:       return OFS_CTRL1;
            4:       return OFS_CTRL1_SET;
            5:       return OFS_CTRL1_CLR;
            6:       return OFS_XFER;
            7:       return OFS_BUF;
            default: return OFS_TIMING;
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return $urandom;
        else if (sel < 45)
            return RUN_BIT;
        else if (sel < 60)
            return FRAME_DONE;
        else if (sel < 70)
            return '0;
        else if (sel < 80)
            return '1;
        else
            return 32'd1 << $urandom_range(31);
    endfunction

    // Width/height pair whose product is the frame size: width in the high half.
    function automatic logic [31:0] matching_xfer();
        int w;
        int h;
        w = (1 << $urandom_range(10)) * ($urandom_range(1) ? 3 : 1) * ($urandom_range(1) ? 5 : 1);
        h = FRAME_SIZE / w;
        return {w[15:0], h[15:0]};
    endfunction

    // Typical driver flow: program size and base, kick a frame, check status, ack the irq.
    task automatic frame_sequence();
        bus_access(MODE_WRITE, OFS_XFER, ($urandom_range(9) < 7) ? matching_xfer() : $urandom);
        if ($urandom_range(1))
            bus_access(MODE_WRITE, OFS_BUF, $urandom);
        bus_access(MODE_WRITE, OFS_CTRL_SET, RUN_BIT);
        bus_access(MODE_READ, $urandom_range(1) ? OFS_CTRL1 : OFS_CTRL, $urandom);
        bus_access(MODE_WRITE, OFS_CTRL1_CLR, ($urandom_range(9) < 8) ? FRAME_DONE : random_word());
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        int start_count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start_count = sent;
        while (sent - start_count < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 30)
                frame_sequence();
            else if ($urandom_range(99) < 10)
                bus_access(1'($urandom_range(1)), OFS_W'($urandom_range(1023)), random_word());
            else
                bus_access(1'($urandom_range(1)), pick_register(), random_word());
        end
        drain_responses();
    endtask

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset values, frame start with and without fetch, aliases, unknown offsets
        bus_access(MODE_READ, OFS_CTRL, '1);
        bus_access(MODE_WRITE, OFS_XFER, {16'd120, 16'd128});
        bus_access(MODE_WRITE, OFS_BUF, '1);
        bus_access(MODE_WRITE, OFS_CTRL_SET, RUN_BIT);
        bus_access(MODE_READ, OFS_CTRL1, '0);
        bus_access(MODE_READ, OFS_CTRL_SET, '0);
        bus_access(MODE_WRITE, OFS_CTRL1_CLR, 32'h0000_0201);
        bus_access(MODE_WRITE, OFS_CTRL1_CLR, FRAME_DONE);
        bus_access(MODE_WRITE, OFS_XFER, '1);
        bus_access(MODE_WRITE, OFS_CTRL_SET, RUN_BIT);
        bus_access(MODE_WRITE, OFS_XFER, '0);
        bus_access(MODE_WRITE, OFS_CTRL_SET, RUN_BIT);
        bus_access(MODE_WRITE, OFS_CTRL, '1);
        bus_access(MODE_WRITE, OFS_CTRL_CLR, 32'hAAAA_AAAA);
        bus_access(MODE_READ, OFS_CTRL, '0);
        bus_access(MODE_WRITE, OFS_CTRL_SET, 32'h0000_0003);
        bus_access(MODE_WRITE, OFS_CTRL1, '0);
        bus_access(MODE_WRITE, OFS_CTRL1_SET, '1);
        bus_access(MODE_READ, OFS_CTRL1, '0);
        bus_access(MODE_WRITE, OFS_TIMING, '1);
        bus_access(MODE_READ, OFS_TIMING, '0);
        bus_access(MODE_READ, OFS_XFER, '0);
        bus_access(MODE_READ, OFS_BUF, '0);
        bus_access(MODE_WRITE, 10'h3FF, RUN_BIT);
        bus_access(MODE_READ, 10'h3FF, '1);
        bus_access(MODE_READ, 10'd612, '0);
        bus_access(MODE_WRITE, 10'h002, RUN_BIT);
        bus_access(MODE_READ, OFS_CTRL_CLR, '1);
        drain_responses();

        random_phase(0, 0);
        random_phase(81, 0);
        random_phase(0, 81);
        random_phase(17, 17);

        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
